[hdl/lzrw_pkg.sv]
// Package: shared types and constants for the LZSS ring window decoder.
package lzrw_pkg;

  localparam int WINDOW_SIZE = 4096;
  localparam int WIN_AW      = $clog2(WINDOW_SIZE);

  typedef logic [WIN_AW-1:0] win_addr_t;

  localparam win_addr_t  WIN_START = win_addr_t'(12'hFEE);
  localparam logic [7:0] BLANK     = 8'h20;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_LIT,
    ST_COPY
  } dec_state_t;

  // Request from the token sequencer to the ring window.
  typedef struct packed {
    logic       clear;
    logic       re;
    win_addr_t  raddr;
    logic       we;
    logic [7:0] wdata;
  } ring_req_t;

endpackage

[hdl/lzrw_ring.sv]
// Ring window: 4096 x 8 memory, write pointer, fill count and read forwarding.
module lzrw_ring (
  input  logic              clk,
  input  logic              rst_n,
  input  lzrw_pkg::ring_req_t req,
  output logic [7:0]        rd_byte
);
  import lzrw_pkg::*;

  logic [7:0]      mem [WINDOW_SIZE];
  logic [7:0]      q_r;
  logic [7:0]      fwd_data_r;
  logic            fwd_r;
  logic            hit_r;
  win_addr_t       wptr_r, wptr_nxt;
  logic [WIN_AW:0] fill_r, fill_nxt;

  win_addr_t       rel_pos;
  logic [WIN_AW:0] fill_eff;
  logic            hit;
  logic            fwd;

  // An entry was written in this stream if it lies within the last fill_r writes.
  always_comb begin
    rel_pos  = req.raddr - WIN_START;
    fill_eff = fill_r + {{WIN_AW{1'b0}}, req.we};
    hit      = fill_r[WIN_AW] || ({1'b0, rel_pos} < fill_eff);
    fwd      = req.we && (req.raddr == wptr_r);
    if (req.clear) begin
      fill_nxt = '0;
      wptr_nxt = WIN_START;
    end else begin
      fill_nxt = (req.we && !fill_r[WIN_AW]) ? fill_r + (WIN_AW+1)'(1) : fill_r;
      wptr_nxt = req.we ? wptr_r + win_addr_t'(1) : wptr_r;
    end
  end

  always_ff @(posedge clk) begin
    if (req.we) begin
      mem[wptr_r] <= req.wdata;
    end
    if (req.re) begin
      q_r        <= mem[req.raddr];
      fwd_r      <= fwd;
      fwd_data_r <= req.wdata;
      hit_r      <= hit;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fill_r <= '0;
      wptr_r <= WIN_START;
    end else begin
      fill_r <= fill_nxt;
      wptr_r <= wptr_nxt;
    end
  end

  assign rd_byte = !hit_r ? BLANK : (fwd_r ? fwd_data_r : q_r);

endmodule

[hdl/lzss_ring_window_decoder.sv]
// Top level: LZSS decoder with a 4096-byte ring window.
//
//  channel | direction | handshake           | payload
//  --------+-----------+---------------------+---------------------------------------
//  in      | input     | in_valid/in_ready   | in_comp_byte[7:0], in_last_byte
//  out     | output    | out_valid/out_ready | out_byte[7:0], out_run_last, out_stream_done
//  cfg     | input     | cfg_wr_en           | cfg_wr_data[31:0] (out_length)
//
// Steps: a flag byte or the first match byte is taken in ST_IDLE alone; a literal is accepted
// in ST_IDLE, then ST_LIT writes it to the ring and loads the output register; the second match
// byte starts ST_COPY for len = 3..18 words, one copied word per cycle unless the output stalls,
// through the single ring read port, the write of word k forwarded to a read of word k+1 at its entry.
// Reset: rst_n is synchronous; the ring needs no clearing pass, a fill count marks
// which entries belong to the current stream. A stalled output word holds the copy.
module lzss_ring_window_decoder (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_wr_en,
  input  logic [31:0] cfg_wr_data,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  in_comp_byte,
  input  logic        in_last_byte,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [7:0]  out_byte,
  output logic        out_run_last,
  output logic        out_stream_done
);
  import lzrw_pkg::*;

  dec_state_t  state_r, state_nxt;
  logic [31:0] out_length_r;
  logic [8:0]  flag_r, flag_nxt;          // remaining flag bits above a stop marker
  logic [31:0] cnt_r, cnt_nxt;            // bytes out in this stream
  logic [7:0]  hold_r, hold_nxt;          // low offset byte of a pending match
  logic        mpend_r, mpend_nxt;        // second match byte is due
  logic        finished_r, finished_nxt;  // length reached, discard until last byte
  logic [7:0]  lit_r, lit_nxt;
  logic        lit_last_r, lit_last_nxt;
  win_addr_t   src_r, src_nxt;            // next copy source
  logic [4:0]  rem_r, rem_nxt;            // copy words left after the one in flight
  logic        ov_r, ov_nxt;
  logic [7:0]  ob_r, ob_nxt;
  logic        orl_r, orl_nxt;
  logic        osd_r, osd_nxt;

  ring_req_t   req;
  logic [7:0]  rd_byte;
  logic        slot_free;
  logic        clr;
  logic [31:0] cnt_inc;
  logic        len_hit;
  win_addr_t   off;

  lzrw_ring u_ring (
    .clk     (clk),
    .rst_n   (rst_n),
    .req     (req),
    .rd_byte (rd_byte)
  );

  always_comb begin
    state_nxt    = state_r;
    flag_nxt     = flag_r;
    cnt_nxt      = cnt_r;
    hold_nxt     = hold_r;
    mpend_nxt    = mpend_r;
    finished_nxt = finished_r;
    lit_nxt      = lit_r;
    lit_last_nxt = lit_last_r;
    src_nxt      = src_r;
    rem_nxt      = rem_r;
    ob_nxt       = ob_r;
    orl_nxt      = orl_r;
    osd_nxt      = osd_r;
    clr          = 1'b0;

    slot_free = !ov_r || out_ready;
    ov_nxt    = ov_r && !out_ready;
    cnt_inc   = cnt_r + 32'd1;
    len_hit   = cnt_inc >= out_length_r;
    off       = {in_comp_byte[7:4], hold_r};
    in_ready  = (state_r == ST_IDLE);

    req       = '0;
    req.raddr = src_r;
    req.wdata = (state_r == ST_LIT) ? lit_r : rd_byte;

    case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          if (finished_r) begin
            // drop words until the stream's last byte
            clr = in_last_byte;
          end else if (mpend_r) begin
            mpend_nxt = 1'b0;
            if (in_last_byte) begin
              clr = 1'b1;
            end else begin
              req.re    = 1'b1;
              req.raddr = off;
              src_nxt   = off + win_addr_t'(1);
              rem_nxt   = {1'b0, in_comp_byte[3:0]} + 5'd2;
              state_nxt = ST_COPY;
            end
          end else if (flag_r <= 9'd1) begin
            flag_nxt = {1'b1, in_comp_byte};
            clr      = in_last_byte;
          end else begin
            flag_nxt = flag_r >> 1;
            if (flag_r[0]) begin
              lit_nxt      = in_comp_byte;
              lit_last_nxt = in_last_byte;
              state_nxt    = ST_LIT;
            end else if (in_last_byte) begin
              clr = 1'b1;
            end else begin
              hold_nxt  = in_comp_byte;
              mpend_nxt = 1'b1;
            end
          end
        end
      end
      ST_LIT: begin
        if (slot_free) begin
          req.we    = 1'b1;
          ov_nxt    = 1'b1;
          ob_nxt    = lit_r;
          orl_nxt   = 1'b1;
          osd_nxt   = len_hit || lit_last_r;
          cnt_nxt   = cnt_inc;
          state_nxt = ST_IDLE;
          if (lit_last_r) begin
            clr = 1'b1;
          end else if (len_hit) begin
            finished_nxt = 1'b1;
          end
        end
      end
      ST_COPY: begin
        // rd_byte holds the word in flight until the output register frees up
        if (slot_free) begin
          req.we  = 1'b1;
          ov_nxt  = 1'b1;
          ob_nxt  = rd_byte;
          orl_nxt = len_hit || (rem_r == 5'd0);
          osd_nxt = len_hit;
          cnt_nxt = cnt_inc;
          if (len_hit) begin
            finished_nxt = 1'b1;
            state_nxt    = ST_IDLE;
          end else if (rem_r == 5'd0) begin
            state_nxt = ST_IDLE;
          end else begin
            req.re  = 1'b1;
            src_nxt = src_r + win_addr_t'(1);
            rem_nxt = rem_r - 5'd1;
          end
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase

    if (clr) begin
      flag_nxt     = '0;
      cnt_nxt      = '0;
      hold_nxt     = '0;
      mpend_nxt    = 1'b0;
      finished_nxt = 1'b0;
    end
    req.clear = clr;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_IDLE;
      out_length_r <= '0;
      flag_r       <= '0;
      cnt_r        <= '0;
      hold_r       <= '0;
      mpend_r      <= 1'b0;
      finished_r   <= 1'b0;
      ov_r         <= 1'b0;
    end else begin
      state_r    <= state_nxt;
      flag_r     <= flag_nxt;
      cnt_r      <= cnt_nxt;
      hold_r     <= hold_nxt;
      mpend_r    <= mpend_nxt;
      finished_r <= finished_nxt;
      ov_r       <= ov_nxt;
      if (cfg_wr_en) begin
        out_length_r <= cfg_wr_data;
      end
    end
  end

  // payload registers: no reset
  always_ff @(posedge clk) begin
    lit_r      <= lit_nxt;
    lit_last_r <= lit_last_nxt;
    src_r      <= src_nxt;
    rem_r      <= rem_nxt;
    ob_r       <= ob_nxt;
    orl_r      <= orl_nxt;
    osd_r      <= osd_nxt;
  end

  assign out_valid       = ov_r;
  assign out_byte        = ob_r;
  assign out_run_last    = orl_r;
  assign out_stream_done = osd_r;

endmodule

[hdl/lzrw_check.sv]
// Checker: port-level properties of the decoder, bound to the top level.
module lzrw_check (
  input logic        clk,
  input logic        rst_n,
  input logic        in_valid,
  input logic        in_ready,
  input logic [7:0]  in_comp_byte,
  input logic        in_last_byte,
  input logic        out_valid,
  input logic        out_ready,
  input logic [7:0]  out_byte,
  input logic        out_run_last,
  input logic        out_stream_done
);

  // hold a stalled output word
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_byte) && $stable(out_run_last))
    else $error("stalled output word changed");

  // hold a waiting input word
  a_in_hold: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_ready |=> in_valid && $stable(in_comp_byte) && $stable(in_last_byte))
    else $error("waiting input word changed");

  // a word that ends the stream also ends its run
  a_done_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stream_done |-> out_run_last)
    else $error("stream_done without run_last");

  // no new input while a match is still being copied
  a_run_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_run_last |-> !in_ready)
    else $error("input taken during a match copy");

  // drop any output word on reset
  a_reset: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("output valid after reset");

endmodule

bind lzss_ring_window_decoder lzrw_check u_lzrw_check (.*);

[tb/sv/tb_lzss_ring_window_decoder.sv]
// Testbench for the LZSS ring window decoder: directed table, random streams, own predictor.
module tb_lzss_ring_window_decoder;
  import lzrw_pkg::*;

  // Hold after an expected result before touching the length register or ending the run:
  // the longest token copies 18 words through the ring, plus the output register.
  localparam int SETTLE_CYCLES = 24;
  // Stop starting new streams once a random phase has sent this many words.
  localparam int PHASE_WORDS   = 20;
  localparam int NUM_PHASES    = 8;

  typedef enum logic {
    ROW_WORD,
    ROW_CFG
  } row_kind_t;

  // One decompressed word as the result channel carries it.
  typedef struct packed {
    logic [7:0] data;
    logic       run_last;
    logic       done;
  } out_word_t;

  // One line of the directed table: an input word or a length write. Typed rows carry a
  // result that is plain to see: n copies of data, done on the final one.
  typedef struct packed {
    row_kind_t   kind;
    logic [31:0] value;
    logic        last;
    logic        typed;
    logic [4:0]  n;
    logic [7:0]  data;
    logic        done;
  } stim_row_t;

  logic        clk = 1'b0;
  logic        rst_n;
  logic        cfg_wr_en;
  logic [31:0] cfg_wr_data;
  logic        in_valid;
  logic        in_ready;
  logic [7:0]  in_comp_byte;
  logic        in_last_byte;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [7:0]  out_byte;
  logic        out_run_last;
  logic        out_stream_done;

  lzss_ring_window_decoder i_dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .cfg_wr_en      (cfg_wr_en),
    .cfg_wr_data    (cfg_wr_data),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_comp_byte   (in_comp_byte),
    .in_last_byte   (in_last_byte),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_byte       (out_byte),
    .out_run_last   (out_run_last),
    .out_stream_done(out_stream_done)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // ---------------------------------------------------------------------------------------
  // Decoder model state: ring contents, per-stream written marks, token tracking.
  // ---------------------------------------------------------------------------------------
  logic [7:0]  win_data  [WINDOW_SIZE];
  logic        win_valid [WINDOW_SIZE];
  logic [8:0]  flag_bits;     // remaining flag bits above a stop marker
  logic [31:0] byte_count;    // decompressed words so far in this stream
  logic [31:0] length_cfg;    // mirror of the out_length register
  logic [7:0]  offset_lo;     // low offset byte of a pending match
  logic [1:0]  match_half;    // 1: second match byte due
  logic        stream_ended;  // length reached, drop words until a last one

  out_word_t decoded_words[$];   // results of the word just decoded
  out_word_t expected_bytes[$];  // results still owed by the block

  int fail_count  = 0;
  int live_words  = 0;
  int send_idle_pct = 0;
  int stall_pct   = 0;
  int hold_len    = 0;
  int hold_seq    = 0;
  int hold_seen   = 0;
  int hold_left   = 0;

  function automatic void clear_stream_state();
    foreach (win_valid[i]) win_valid[i] = 1'b0;
    byte_count   = '0;
    flag_bits    = '0;
    offset_lo    = '0;
    match_half   = '0;
    stream_ended = 1'b0;
  endfunction

  // Write one word into the ring and the result list; report whether the length is reached.
  function automatic logic put_byte(logic [7:0] v);
    win_addr_t pos;
    pos = WIN_START + byte_count[WIN_AW-1:0];
    win_data[pos]  = v;
    win_valid[pos] = 1'b1;
    byte_count     = byte_count + 32'd1;
    decoded_words.insert(decoded_words.size(), '{v, 1'b0, 1'b0});
    return byte_count >= length_cfg;
  endfunction

  // Advance the model by one accepted input word; return 1 when the word was dropped
  // because the stream had already reached its length.
  function automatic logic decode_word(logic [7:0] b, logic last);
    win_addr_t base;
    win_addr_t src;
    int        len;
    logic      hit;
    logic      lit_flag;
    out_word_t w;
    decoded_words.delete();
    if (stream_ended) begin
      if (last) clear_stream_state();
      return 1'b1;
    end
    if (match_half == 2'd1) begin
      match_half = 2'd0;
      if (last) begin
        clear_stream_state();
        return 1'b0;
      end
      base = {b[7:4], offset_lo};
      len  = int'(b[3:0]) + 3;
      hit  = 1'b0;
      for (int k = 0; k < len && !hit; k++) begin
        src = base + win_addr_t'(k);
        hit = put_byte(win_valid[src] ? win_data[src] : BLANK);
      end
      w = decoded_words.pop_back();
      w.run_last = 1'b1;
      if (hit) begin
        w.done       = 1'b1;
        stream_ended = 1'b1;
      end
      decoded_words.insert(decoded_words.size(), w);
      return 1'b0;
    end
    match_half = 2'd0;
    if (flag_bits <= 9'd1) begin
      flag_bits = {1'b1, b};
      if (last) clear_stream_state();
      return 1'b0;
    end
    lit_flag  = flag_bits[0];
    flag_bits = flag_bits >> 1;
    if (lit_flag) begin
      hit = put_byte(b);
      w = decoded_words.pop_back();
      w.run_last = 1'b1;
      if (hit || last) begin
        w.done = 1'b1;
        if (last) clear_stream_state();
        else stream_ended = 1'b1;
      end
      decoded_words.insert(decoded_words.size(), w);
      return 1'b0;
    end
    if (last) begin
      clear_stream_state();
      return 1'b0;
    end
    offset_lo  = b;
    match_half = 2'd1;
    return 1'b0;
  endfunction

  // ---------------------------------------------------------------------------------------
  // Result side: drive out_ready at the falling edge, check words at the rising edge.
  // ---------------------------------------------------------------------------------------
  always @(negedge clk) begin
    // A new hold-off request starts a long stretch with ready low; the sender keeps
    // offering words meanwhile so the block backs up into its input.
    if (hold_seq != hold_seen) begin
      hold_seen = hold_seq;
      hold_left = hold_len;
    end
    if (hold_left > 0) begin
      out_ready = 1'b0;
      hold_left--;
    end else begin
      out_ready = ($urandom_range(99) >= stall_pct);
    end
  end

  out_word_t got_word;
  out_word_t want_word;

  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      got_word = '{out_byte, out_run_last, out_stream_done};
      if (expected_bytes.size() == 0) begin
        $display("%0t: unexpected word: got byte=%02h run_last=%b stream_done=%b",
                 $time, got_word.data, got_word.run_last, got_word.done);
        fail_count++;
      end else begin
        want_word = expected_bytes.pop_front();
        if (got_word !== want_word) begin
          $display({"%0t: mismatch: expected byte=%02h run_last=%b stream_done=%b,",
                    " got byte=%02h run_last=%b stream_done=%b"},
                   $time, want_word.data, want_word.run_last, want_word.done,
                   got_word.data, got_word.run_last, got_word.done);
          fail_count++;
        end
      end
    end
  end

  // ---------------------------------------------------------------------------------------
  // Input side. All tasks start and end at a falling edge.
  // ---------------------------------------------------------------------------------------

  // Offer one word, hold it until accepted, then run it through the model.
  task automatic send_word(input logic [7:0] b, input logic last);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid = 1'b0;
      @(negedge clk);
    end
    in_valid     = 1'b1;
    in_comp_byte = b;
    in_last_byte = last;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    void'(decode_word(b, last));
    @(negedge clk);
  endtask

  // Send one word and queue whatever the model predicts for it.
  task automatic send_pred(input logic [7:0] b, input logic last);
    send_word(b, last);
    foreach (decoded_words[i]) expected_bytes.insert(expected_bytes.size(), decoded_words[i]);
    live_words++;
  endtask

  // Drop valid, wait for every owed word, then let the block settle.
  task automatic wait_idle();
    in_valid = 1'b0;
    while (expected_bytes.size() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic write_length(input logic [31:0] v);
    cfg_wr_en   = 1'b1;
    cfg_wr_data = v;
    @(negedge clk);
    cfg_wr_en   = 1'b0;
    length_cfg  = v;
  endtask

  // One compressed stream: mostly well-formed tokens with random content, sometimes noise.
  task automatic gen_stream();
    int         ntok;
    int         n_noise;
    int         pick;
    int         reach;
    logic       flag_end;
    logic       end_here;
    logic [7:0] flags;
    win_addr_t  wpos;
    win_addr_t  src;
    if ($urandom_range(9) == 0) begin
      // Noise: random bytes, a stray last now and then, closed by a last.
      n_noise = $urandom_range(1, 12);
      for (int i = 0; i < n_noise; i++)
        send_pred(8'($urandom), i == n_noise - 1 || $urandom_range(15) == 0);
      return;
    end
    // Now and then end right where a new flag byte is due, with that flag byte.
    flag_end = ($urandom_range(9) == 0);
    ntok     = flag_end ? 8 * $urandom_range(1, 2) : $urandom_range(1, 24);
    flags    = '0;
    for (int t = 0; t < ntok; t++) begin
      if (t % 8 == 0) begin
        flags = 8'($urandom);
        // Mostly close on a literal; otherwise the closing token stays random and a closing match gets cut.
        if (!flag_end && ntok - t <= 8 && $urandom_range(9) < 7)
          flags[(ntok - 1) % 8] = 1'b1;
        send_pred(flags, 1'b0);
      end
      end_here = !flag_end && t == ntok - 1;
      if (flags[t % 8]) begin
        send_pred(8'($urandom), end_here);
      end else begin
        // Aim the offset at recent output, a short overlapping run, the write position
        // itself, or anywhere in the ring.
        wpos  = WIN_START + byte_count[WIN_AW-1:0];
        reach = (byte_count > 32'd300) ? 300 : int'(byte_count);
        pick  = $urandom_range(99);
        if (pick < 45 && reach > 0) src = wpos - win_addr_t'($urandom_range(1, reach));
        else if (pick < 65) src = wpos - win_addr_t'($urandom_range(1, 3));
        else if (pick < 75) src = wpos;
        else src = win_addr_t'($urandom);
        if (end_here && $urandom_range(1) == 0) begin
          send_pred(src[7:0], 1'b1);
        end else begin
          send_pred(src[7:0], 1'b0);
          send_pred({src[11:8], 4'($urandom)}, end_here);
        end
      end
    end
    if (flag_end) send_pred(8'($urandom), 1'b1);
  endtask

  function automatic stim_row_t word_row(logic [7:0] b, logic last);
    return '{ROW_WORD, {24'd0, b}, last, 1'b0, 5'd0, 8'h00, 1'b0};
  endfunction

  function automatic stim_row_t typed_row(logic [7:0] b, logic last, logic [4:0] n,
                                          logic [7:0] data, logic done);
    return '{ROW_WORD, {24'd0, b}, last, 1'b1, n, data, done};
  endfunction

  function automatic stim_row_t length_row(logic [31:0] v);
    return '{ROW_CFG, v, 1'b0, 1'b0, 5'd0, 8'h00, 1'b0};
  endfunction

  // Per-phase length and idling for the random part. Modes cycle through: no idling,
  // sender idle half the time, receiver stalling half the time, both 26 percent of the time.
  logic [31:0] phase_length [NUM_PHASES] = '{32'hFFFF_FFFF, 32'd90, 32'hFFFF_FFFF, 32'd0,
                                             32'hFFFF_FFFF, 32'd300, 32'd1, 32'hFFFF_FFFF};
  int          phase_send   [4] = '{0, 50, 0, 26};
  int          phase_stall  [4] = '{0, 0, 50, 26};

  stim_row_t directed[$];

  initial begin
    cfg_wr_en    = 1'b0;
    cfg_wr_data  = '0;
    in_valid     = 1'b0;
    in_comp_byte = '0;
    in_last_byte = 1'b0;
    rst_n        = 1'b0;
    length_cfg   = '0;
    foreach (win_data[i]) win_data[i] = 8'h00;
    clear_stream_state();

    directed = '{
      // Reset length is zero: the first word out already ends the stream,
      // then words are dropped until one carries last.
      typed_row(8'hFF, 1'b0, 5'd0, 8'h00, 1'b0),
      typed_row(8'h00, 1'b0, 5'd1, 8'h00, 1'b1),
      typed_row(8'hAB, 1'b0, 5'd0, 8'h00, 1'b0),
      typed_row(8'h55, 1'b1, 5'd0, 8'h00, 1'b0),
      length_row(32'hFFFF_FFFF),
      // Flag: match, literal, then matches only.
      typed_row(8'h02, 1'b0, 5'd0, 8'h00, 1'b0),
      // Longest match from offset 0, nothing written there yet: all spaces.
      word_row(8'h00, 1'b0),
      typed_row(8'h0F, 1'b0, 5'd18, 8'h20, 1'b0),
      typed_row(8'hFF, 1'b0, 5'd1, 8'hFF, 1'b0),
      // Offset FFF: copy wraps the ring and reads a word written in the same match.
      word_row(8'hFF, 1'b0),
      word_row(8'hF0, 1'b0),
      // One behind the write position: a run fed by forwarding.
      word_row(8'h03, 1'b0),
      word_row(8'h0F, 1'b0),
      // Offset equal to the write position: full-window reference.
      word_row(8'h16, 1'b0),
      word_row(8'h00, 1'b0),
      // Second match byte carries last: match dropped, stream cleared.
      word_row(8'h12, 1'b0),
      typed_row(8'h34, 1'b1, 5'd0, 8'h00, 1'b0),
      // A flag byte as the last word.
      typed_row(8'h00, 1'b1, 5'd0, 8'h00, 1'b0),
      // Literal carrying last ends the stream.
      typed_row(8'hFF, 1'b0, 5'd0, 8'h00, 1'b0),
      typed_row(8'h80, 1'b1, 5'd1, 8'h80, 1'b1),
      // First match byte carries last.
      typed_row(8'h00, 1'b0, 5'd0, 8'h00, 1'b0),
      typed_row(8'h11, 1'b1, 5'd0, 8'h00, 1'b0),
      // Length reached inside a match: five spaces, then drop until last.
      length_row(32'd5),
      typed_row(8'h00, 1'b0, 5'd0, 8'h00, 1'b0),
      word_row(8'h00, 1'b0),
      typed_row(8'h0F, 1'b0, 5'd5, 8'h20, 1'b1),
      typed_row(8'h77, 1'b0, 5'd0, 8'h00, 1'b0),
      typed_row(8'h01, 1'b1, 5'd0, 8'h00, 1'b0)
    };

    repeat (3) @(negedge clk);
    rst_n = 1'b1;

    // Directed table: typed rows supply their own result, the rest go through the model.
    foreach (directed[i]) begin
      if (directed[i].kind == ROW_CFG) begin
        wait_idle();
        write_length(directed[i].value);
      end else begin
        send_word(directed[i].value[7:0], directed[i].last);
        if (directed[i].typed) begin
          for (int k = 0; k < int'(directed[i].n); k++)
            expected_bytes.insert(expected_bytes.size(),
                                  '{directed[i].data, k == int'(directed[i].n) - 1,
                                    k == int'(directed[i].n) - 1 && directed[i].done});
        end else begin
          foreach (decoded_words[j])
            expected_bytes.insert(expected_bytes.size(), decoded_words[j]);
        end
      end
    end

    // Random phases; each starts from an idle block with a fresh length.
    for (int p = 0; p < NUM_PHASES; p++) begin
      wait_idle();
      write_length(phase_length[p]);
      send_idle_pct = phase_send[p % 4];
      stall_pct     = phase_stall[p % 4];
      if (p == 0) begin
        hold_len = 300;
        hold_seq++;
      end
      live_words = 0;
      while (live_words < PHASE_WORDS) gen_stream();
    end

    wait_idle();
    if (fail_count == 0) begin
      $display("tb_lzss_ring_window_decoder passed");
    end else begin
      $display("tb_lzss_ring_window_decoder failed");
    end
    $finish;
  end

  // Watchdog: far beyond the slowest correct run.
  initial begin
    #3000000;
    $display("tb_lzss_ring_window_decoder failed");
    $finish;
  end

endmodule

[filelist.f]
hdl/lzrw_pkg.sv
hdl/lzrw_ring.sv
hdl/lzss_ring_window_decoder.sv
hdl/lzrw_check.sv
tb/sv/tb_lzss_ring_window_decoder.sv
